[rtl/cip_pkg.sv]
// Shared widths, lane codes and sideband types for the circle intersection unit.
`default_nettype none
package cip_pkg;

  // Coordinate format.
  localparam int CW   = 24;
  localparam int FRAC = 12;

  // Widths derived from the coordinate width.
  localparam int DW    = CW + 1;        // centre difference
  localparam int ABW   = CW + 2;        // signed line coefficients a and b
  localparam int AMW   = CW + 1;        // magnitude of a or b
  localparam int RW    = CW - 1;        // radius
  localparam int SQW   = 2 * CW;        // square of a centre difference
  localparam int RSQW  = 2 * CW - 2;    // square of a radius
  localparam int CCW   = 2 * CW + 3;    // signed coefficient c
  localparam int CMW   = 2 * CW + 2;    // magnitude of c
  localparam int SW    = 2 * CW + 3;    // a*a + b*b
  localparam int PQW   = 4 * CW + 4;    // r*r*S and c*c
  localparam int RTW   = PQW / 2;       // square root result
  localparam int TW    = 4 * FRAC + 16; // shifted tangent tolerance
  localparam int TSH   = 4 * FRAC - 16;
  localparam int PRW   = AMW + CMW;     // numerator products
  localparam int NUMW  = PRW + 2;       // signed numerators and rounded magnitudes
  localparam int QW    = CW + 1;        // quotient bits before saturation
  localparam int LANES = 4;

  // Result lane codes.
  localparam int LANE_FIRST_X  = 0;
  localparam int LANE_FIRST_Y  = 1;
  localparam int LANE_SECOND_X = 2;
  localparam int LANE_SECOND_Y = 3;

  // Point count codes.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Geometry carried alongside the discriminant work.
  typedef struct packed {
    logic signed [ABW-1:0] a;
    logic signed [ABW-1:0] b;
    logic [CMW-1:0]        cm;
    logic                  cneg;
    logic [SW-1:0]         s;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
  } geo_t;

  // Sideband of the square root stages.
  typedef struct packed {
    geo_t       g;
    logic [1:0] count;
  } root_sb_t;

  // Sideband of the divider stages.
  typedef struct packed {
    logic [1:0]           count;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } div_sb_t;

endpackage
`default_nettype wire

[rtl/cip_umul.sv]
// Two stage unsigned multiplier built from four half width partial products.
`default_nettype none
module cip_umul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic [AW+BW-1:0]   p
);
  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] ll_r;
  logic [AL+BH-1:0] lh_r;
  logic [AH+BL-1:0] hl_r;
  logic [AH+BH-1:0] hh_r;
  logic [PW-1:0]    p_r;

  // Partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
      lh_r <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
      hl_r <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
      hh_r <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
    end
  end

  // Alignment and final sum.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PW'(ll_r) + (PW'(lh_r) << BL) + (PW'(hl_r) << AL) + (PW'(hh_r) << (AL + BL));
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

[rtl/cip_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module cip_isqrt #(
  parameter int IW  = 8,
  parameter int SBW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [IW-1:0]  in_radicand,
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_valid,
  output logic [IW/2-1:0]     out_root,
  output logic [SBW-1:0]      out_sb
);
  localparam int RW = IW / 2;

  logic [IW-1:0]  rem_r  [RW+1];
  logic [RW-1:0]  root_r [RW+1];
  logic [SBW-1:0] sb_r   [RW+1];
  logic [RW:0]    v_r;

  // Entry stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_radicand;
      root_r[0] <= '0;
      sb_r[0]   <= in_sb;
    end
  end

  // Each stage tries one root bit, from the top, against the running remainder.
  for (genvar k = 1; k <= RW; k++) begin : g_stage
    localparam int I = RW - k;
    logic [IW-1:0] trial;
    logic          take;
    logic [IW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;

    always_comb begin
      trial    = (IW'(root_r[k-1]) << (I + 1)) | (IW'(1) << (2 * I));
      take     = (rem_r[k-1] >= trial);
      rem_nxt  = take ? (rem_r[k-1] - trial) : rem_r[k-1];
      root_nxt = take ? (root_r[k-1] | (RW'(1) << I)) : root_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= sb_r[k-1];
      end
    end
  end

  assign out_valid = v_r[RW];
  assign out_root  = root_r[RW];
  assign out_sb    = sb_r[RW];

endmodule
`default_nettype wire

[rtl/cip_div.sv]
// Four lane pipelined restoring divider with a shared divisor and overflow detection.
`default_nettype none
module cip_div #(
  parameter int NW  = 16,
  parameter int DW  = 8,
  parameter int QW  = 8,
  parameter int SBW = 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [cip_pkg::LANES-1:0][NW-1:0] in_num,
  input  wire logic [cip_pkg::LANES-1:0]        in_neg,
  input  wire logic [DW-1:0]                    in_den,
  input  wire logic [SBW-1:0]                   in_sb,
  output logic                                  out_valid,
  output logic [cip_pkg::LANES-1:0][QW-1:0]     out_quo,
  output logic [cip_pkg::LANES-1:0]             out_ovf,
  output logic [cip_pkg::LANES-1:0]             out_neg,
  output logic [SBW-1:0]                        out_sb
);
  localparam int L = cip_pkg::LANES;

  logic [L-1:0][NW-1:0] rem_r [QW+1];
  logic [L-1:0][QW-1:0] quo_r [QW+1];
  logic [L-1:0]         ovf_r [QW+1];
  logic [L-1:0]         neg_r [QW+1];
  logic [DW-1:0]        den_r [QW+1];
  logic [SBW-1:0]       sb_r  [QW+1];
  logic [QW:0]          v_r;
  logic [L-1:0]         ovf_nxt;

  // Entry stage: a quotient that needs more than QW bits is flagged here.
  always_comb begin
    for (int l = 0; l < L; l++) begin
      ovf_nxt[l] = (in_num[l] >= (NW'(in_den) << QW));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_num;
      quo_r[0] <= '0;
      ovf_r[0] <= ovf_nxt;
      neg_r[0] <= in_neg;
      den_r[0] <= in_den;
      sb_r[0]  <= in_sb;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int I = QW - k;
    logic [NW-1:0]        trial;
    logic [L-1:0][NW-1:0] rem_nxt;
    logic [L-1:0][QW-1:0] quo_nxt;

    always_comb begin
      trial = NW'(den_r[k-1]) << I;
      for (int l = 0; l < L; l++) begin
        if (rem_r[k-1][l] >= trial) begin
          rem_nxt[l] = rem_r[k-1][l] - trial;
          quo_nxt[l] = {quo_r[k-1][l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = rem_r[k-1][l];
          quo_nxt[l] = {quo_r[k-1][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
        den_r[k] <= den_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_ovf   = ovf_r[QW];
  assign out_neg   = neg_r[QW];
  assign out_sb    = sb_r[QW];

  // Lane 0, when it has no overflow, must leave a remainder below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QW] && !ovf_r[QW][0] |-> rem_r[QW][0] < NW'(den_r[QW]))
    else $error("divider lane 0 remainder not below divisor");

endmodule
`default_nettype wire

[rtl/circle_intersection_points_unit.sv]
// Circle against line or circle intersection unit, fully pipelined.
// Throughput: one word per cycle; the square root (51 stages) and the
// divider (26 stages) are unrolled, so every stage takes a new word each cycle.
// A stall on the result side holds the whole pipeline, input included.
// Reset (synchronous, active low) empties the pipeline and sets the tolerance to 66.
`default_nettype none
module circle_intersection_points_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic signed [cip_pkg::CW-1:0] in_center_x,
  input  wire logic signed [cip_pkg::CW-1:0] in_center_y,
  input  wire logic [cip_pkg::CW-2:0]        in_radius,
  input  wire logic signed [cip_pkg::CW-1:0] in_other_x,
  input  wire logic signed [cip_pkg::CW-1:0] in_other_y,
  input  wire logic [cip_pkg::CW-2:0]        in_other_radius,
  input  wire logic signed [cip_pkg::CW-1:0] in_line_a,
  input  wire logic signed [cip_pkg::CW-1:0] in_line_b,
  input  wire logic signed [2*cip_pkg::CW-1:0] in_line_c,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_point_count,
  output logic signed [cip_pkg::CW-1:0]      out_first_x,
  output logic signed [cip_pkg::CW-1:0]      out_first_y,
  output logic signed [cip_pkg::CW-1:0]      out_second_x,
  output logic signed [cip_pkg::CW-1:0]      out_second_y,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [31:0]                   cfg_tangent_tolerance
);
  localparam int CW   = cip_pkg::CW;
  localparam int DW   = cip_pkg::DW;
  localparam int ABW  = cip_pkg::ABW;
  localparam int AMW  = cip_pkg::AMW;
  localparam int RW   = cip_pkg::RW;
  localparam int SQW  = cip_pkg::SQW;
  localparam int RSQW = cip_pkg::RSQW;
  localparam int CCW  = cip_pkg::CCW;
  localparam int CMW  = cip_pkg::CMW;
  localparam int SW   = cip_pkg::SW;
  localparam int PQW  = cip_pkg::PQW;
  localparam int RTW  = cip_pkg::RTW;
  localparam int TW   = cip_pkg::TW;
  localparam int TSH  = cip_pkg::TSH;
  localparam int PRW  = cip_pkg::PRW;
  localparam int NUMW = cip_pkg::NUMW;
  localparam int QW   = cip_pkg::QW;
  localparam int L    = cip_pkg::LANES;
  localparam int RSBW = $bits(cip_pkg::root_sb_t);
  localparam int DSBW = $bits(cip_pkg::div_sb_t);

  localparam logic signed [CW-1:0]   COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]   COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [QW+1:0]   SUM_MAX   = (QW+2)'(COORD_MAX);
  localparam logic signed [QW+1:0]   SUM_MIN   = (QW+2)'(COORD_MIN);

  logic en;

  // The whole pipeline advances unless a finished word is held at the output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Tolerance register.
  logic [31:0] tol_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 32'd66;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_tangent_tolerance;
    end
  end

  // Stage 1: capture the word and form the centre differences.
  logic                  v1_r, f1_r;
  logic signed [CW-1:0]  cx1_r, cy1_r, la1_r, lb1_r;
  logic [RW-1:0]         r1_r, r21_r;
  logic signed [DW-1:0]  dx1_r, dy1_r;
  logic signed [2*CW-1:0] lc1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= in_func;
      cx1_r <= in_center_x;
      cy1_r <= in_center_y;
      r1_r  <= in_radius;
      r21_r <= in_other_radius;
      dx1_r <= DW'(in_other_x) - DW'(in_center_x);
      dy1_r <= DW'(in_other_y) - DW'(in_center_y);
      la1_r <= in_line_a;
      lb1_r <= in_line_b;
      lc1_r <= in_line_c;
    end
  end

  // Stage 2: squares of the differences and radii, and the coefficients a and b.
  logic                   v2_r, f2_r;
  logic signed [CW-1:0]   cx2_r, cy2_r;
  logic [SQW-1:0]         dxsq2_r, dysq2_r;
  logic [RSQW-1:0]        rsq2_r, r2sq2_r;
  logic signed [ABW-1:0]  a2_r, b2_r;
  logic signed [2*CW-1:0] lc2_r;
  logic [CW-1:0]          dxm_nxt, dym_nxt;
  logic signed [ABW-1:0]  a2_nxt, b2_nxt;

  always_comb begin
    dxm_nxt = CW'(dx1_r[DW-1] ? -dx1_r : dx1_r);
    dym_nxt = CW'(dy1_r[DW-1] ? -dy1_r : dy1_r);
    a2_nxt  = f1_r ? -(ABW'(dx1_r) <<< 1) : ABW'(la1_r);
    b2_nxt  = f1_r ? -(ABW'(dy1_r) <<< 1) : ABW'(lb1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r    <= f1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      dxsq2_r <= SQW'(dxm_nxt) * SQW'(dxm_nxt);
      dysq2_r <= SQW'(dym_nxt) * SQW'(dym_nxt);
      rsq2_r  <= RSQW'(r1_r) * RSQW'(r1_r);
      r2sq2_r <= RSQW'(r21_r) * RSQW'(r21_r);
      a2_r    <= a2_nxt;
      b2_r    <= b2_nxt;
      lc2_r   <= lc1_r;
    end
  end

  // Stage 3: coefficient c, and the squares of a and b.
  logic                  v3_r;
  logic signed [CW-1:0]  cx3_r, cy3_r;
  logic signed [ABW-1:0] a3_r, b3_r;
  logic signed [CCW-1:0] c3_r;
  logic [SW-1:0]         asq3_r, bsq3_r;
  logic [RSQW-1:0]       rsq3_r;
  logic [CCW-1:0]        csum_nxt;
  logic signed [CCW-1:0] c3_nxt;
  logic [AMW-1:0]        am_nxt, bm_nxt;

  always_comb begin
    csum_nxt = CCW'(dxsq2_r) + CCW'(dysq2_r) + CCW'(rsq2_r) - CCW'(r2sq2_r);
    c3_nxt   = f2_r ? $signed(csum_nxt) : CCW'(lc2_r);
    am_nxt   = AMW'(a2_r[ABW-1] ? -a2_r : a2_r);
    bm_nxt   = AMW'(b2_r[ABW-1] ? -b2_r : b2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx3_r  <= cx2_r;
      cy3_r  <= cy2_r;
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      c3_r   <= c3_nxt;
      asq3_r <= SW'(am_nxt) * SW'(am_nxt);
      bsq3_r <= SW'(bm_nxt) * SW'(bm_nxt);
      rsq3_r <= rsq2_r;
    end
  end

  // Stage 4: S = a*a + b*b and the magnitude of c.
  logic            v4_r;
  cip_pkg::geo_t   g4_r;
  logic [RSQW-1:0] rsq4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g4_r.a    <= a3_r;
      g4_r.b    <= b3_r;
      g4_r.cm   <= CMW'(c3_r[CCW-1] ? -c3_r : c3_r);
      g4_r.cneg <= c3_r[CCW-1];
      g4_r.s    <= asq3_r + bsq3_r;
      g4_r.cx   <= cx3_r;
      g4_r.cy   <= cy3_r;
      rsq4_r    <= rsq3_r;
    end
  end

  // Stages 5 and 6: P = r*r*S and Q = c*c.
  logic [RSQW+SW-1:0] p_w;
  logic [2*CMW-1:0]   q_w;
  logic               v5_r, v6_r;
  cip_pkg::geo_t      g5_r, g6_r;

  cip_umul #(.AW(RSQW), .BW(SW)) u_mul_p (
    .clk(clk), .en(en), .a(rsq4_r), .b(g4_r.s), .p(p_w)
  );

  cip_umul #(.AW(CMW), .BW(CMW)) u_mul_q (
    .clk(clk), .en(en), .a(g4_r.cm), .b(g4_r.cm), .p(q_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g5_r <= g4_r;
      g6_r <= g5_r;
    end
  end

  // Stage 7: both differences of P and Q, and which one is larger.
  logic          v7_r, pos7_r;
  logic [PQW-1:0] qp7_r, pq7_r;
  cip_pkg::geo_t g7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos7_r <= (PQW'(q_w) > PQW'(p_w));
      qp7_r  <= PQW'(q_w) - PQW'(p_w);
      pq7_r  <= PQW'(p_w) - PQW'(q_w);
      g7_r   <= g6_r;
    end
  end

  // Classification against the tolerance band; feeds the square root entry.
  logic [PQW-1:0]      tol_w;
  logic [1:0]          count_nxt;
  logic [PQW-1:0]      rad_nxt;
  cip_pkg::root_sb_t   rsb_nxt;

  always_comb begin
    tol_w = PQW'(TW'(tol_r) << TSH);
    if (g7_r.s == '0) begin
      count_nxt = cip_pkg::CNT_NONE;
    end else if (pos7_r) begin
      if (qp7_r > tol_w) begin
        count_nxt = cip_pkg::CNT_NONE;
      end else if (qp7_r < tol_w) begin
        count_nxt = cip_pkg::CNT_ONE;
      end else begin
        count_nxt = cip_pkg::CNT_TWO;
      end
    end else if (pq7_r < tol_w) begin
      count_nxt = cip_pkg::CNT_ONE;
    end else begin
      count_nxt = cip_pkg::CNT_TWO;
    end
    rad_nxt       = pos7_r ? '0 : pq7_r;
    rsb_nxt.g     = g7_r;
    rsb_nxt.count = count_nxt;
  end

  // Square root of the discriminant.
  logic              sq_v_w;
  logic [RTW-1:0]    root_w;
  logic [RSBW-1:0]   sq_sb_w;
  cip_pkg::root_sb_t sq_sb;

  cip_isqrt #(.IW(PQW), .SBW(RSBW)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v7_r), .in_radicand(rad_nxt), .in_sb(rsb_nxt),
    .out_valid(sq_v_w), .out_root(root_w), .out_sb(sq_sb_w)
  );

  assign sq_sb = sq_sb_w;

  // Two stages of numerator products: a*c, b*c, a*s and b*s.
  logic [AMW-1:0] am_w, bm_w;
  logic [PRW-1:0] ac_w, bc_w, as_w, bs_w;

  assign am_w = AMW'(sq_sb.g.a[ABW-1] ? -sq_sb.g.a : sq_sb.g.a);
  assign bm_w = AMW'(sq_sb.g.b[ABW-1] ? -sq_sb.g.b : sq_sb.g.b);

  cip_umul #(.AW(AMW), .BW(CMW)) u_mul_ac (
    .clk(clk), .en(en), .a(am_w), .b(sq_sb.g.cm), .p(ac_w)
  );
  cip_umul #(.AW(AMW), .BW(CMW)) u_mul_bc (
    .clk(clk), .en(en), .a(bm_w), .b(sq_sb.g.cm), .p(bc_w)
  );
  cip_umul #(.AW(AMW), .BW(RTW)) u_mul_as (
    .clk(clk), .en(en), .a(am_w), .b(root_w), .p(as_w)
  );
  cip_umul #(.AW(AMW), .BW(RTW)) u_mul_bs (
    .clk(clk), .en(en), .a(bm_w), .b(root_w), .p(bs_w)
  );

  logic              vm1_r, vm2_r;
  cip_pkg::root_sb_t m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
    end else if (en) begin
      vm1_r <= sq_v_w;
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= sq_sb;
      m2_r <= m1_r;
    end
  end

  // Apply a sign to a product magnitude.
  function automatic logic signed [NUMW-1:0] signed_of(input logic [PRW-1:0] mag,
                                                       input logic neg);
    logic signed [NUMW-1:0] v;
    v = $signed(NUMW'(mag));
    return neg ? -v : v;
  endfunction

  // Numerator sums for both points.
  logic                          vn_r;
  logic signed [L-1:0][NUMW-1:0] num_r;
  logic [SW-1:0]                 sn_r;
  cip_pkg::div_sb_t              dn_r;
  logic signed [NUMW-1:0]        sac_w, sbc_w, sas_w, sbs_w;
  logic                          an_w, bn_w;

  always_comb begin
    an_w  = m2_r.g.a[ABW-1];
    bn_w  = m2_r.g.b[ABW-1];
    sac_w = signed_of(ac_w, an_w ^ m2_r.g.cneg);
    sbc_w = signed_of(bc_w, bn_w ^ m2_r.g.cneg);
    sas_w = signed_of(as_w, an_w);
    sbs_w = signed_of(bs_w, bn_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else if (en) begin
      vn_r <= vm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[cip_pkg::LANE_FIRST_X]  <= -sac_w + sbs_w;
      num_r[cip_pkg::LANE_FIRST_Y]  <= -sbc_w - sas_w;
      num_r[cip_pkg::LANE_SECOND_X] <= -sac_w - sbs_w;
      num_r[cip_pkg::LANE_SECOND_Y] <= -sbc_w + sas_w;
      sn_r                          <= m2_r.g.s;
      dn_r.count                    <= m2_r.count;
      dn_r.cx                       <= m2_r.g.cx;
      dn_r.cy                       <= m2_r.g.cy;
    end
  end

  // Magnitudes with half the divisor added for rounding to nearest.
  logic                   vr_r;
  logic [L-1:0][NUMW-1:0] rnd_r;
  logic [L-1:0]           neg_r;
  logic [SW-1:0]          sr_r;
  cip_pkg::div_sb_t       dr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= 1'b0;
    end else if (en) begin
      vr_r <= vn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        rnd_r[l] <= NUMW'(num_r[l][NUMW-1] ? -num_r[l] : num_r[l]) + NUMW'(sn_r >> 1);
        neg_r[l] <= num_r[l][NUMW-1];
      end
      sr_r <= sn_r;
      dr_r <= dn_r;
    end
  end

  // Division by S.
  logic                 dv_w;
  logic [L-1:0][QW-1:0] quo_w;
  logic [L-1:0]         ovf_w, qneg_w;
  logic [DSBW-1:0]      dsb_w;
  cip_pkg::div_sb_t     dsb;

  cip_div #(.NW(NUMW), .DW(SW), .QW(QW), .SBW(DSBW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vr_r), .in_num(rnd_r), .in_neg(neg_r), .in_den(sr_r), .in_sb(dr_r),
    .out_valid(dv_w), .out_quo(quo_w), .out_ovf(ovf_w), .out_neg(qneg_w), .out_sb(dsb_w)
  );

  assign dsb = dsb_w;

  // Signed quotient plus centre, saturated to the coordinate range.
  function automatic logic signed [CW-1:0] place(input logic [QW-1:0] q,
                                                 input logic ovf,
                                                 input logic neg,
                                                 input logic signed [CW-1:0] centre);
    logic signed [QW:0]   v;
    logic signed [QW+1:0] sum;
    logic signed [CW-1:0] res;
    v   = $signed({1'b0, q});
    v   = neg ? -v : v;
    sum = (QW+2)'(v) + (QW+2)'(centre);
    if (ovf) begin
      res = neg ? COORD_MIN : COORD_MAX;
    end else if (sum > SUM_MAX) begin
      res = COORD_MAX;
    end else if (sum < SUM_MIN) begin
      res = COORD_MIN;
    end else begin
      res = CW'(sum);
    end
    return res;
  endfunction

  // Output register.
  logic                  out_valid_r;
  logic [1:0]            count_r;
  logic signed [CW-1:0]  fx_r, fy_r, sx_r, sy_r;
  logic                  none_w;

  assign none_w = (dsb.count == cip_pkg::CNT_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      count_r <= dsb.count;
      fx_r <= none_w ? '0 : place(quo_w[cip_pkg::LANE_FIRST_X], ovf_w[cip_pkg::LANE_FIRST_X],
                                  qneg_w[cip_pkg::LANE_FIRST_X], dsb.cx);
      fy_r <= none_w ? '0 : place(quo_w[cip_pkg::LANE_FIRST_Y], ovf_w[cip_pkg::LANE_FIRST_Y],
                                  qneg_w[cip_pkg::LANE_FIRST_Y], dsb.cy);
      sx_r <= none_w ? '0 : place(quo_w[cip_pkg::LANE_SECOND_X], ovf_w[cip_pkg::LANE_SECOND_X],
                                  qneg_w[cip_pkg::LANE_SECOND_X], dsb.cx);
      sy_r <= none_w ? '0 : place(quo_w[cip_pkg::LANE_SECOND_Y], ovf_w[cip_pkg::LANE_SECOND_Y],
                                  qneg_w[cip_pkg::LANE_SECOND_Y], dsb.cy);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_count = count_r;
  assign out_first_x     = fx_r;
  assign out_first_y     = fy_r;
  assign out_second_x    = sx_r;
  assign out_second_y    = sy_r;

  // A word with no points carries zero coordinates.
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_count == cip_pkg::CNT_NONE |->
      out_first_x == '0 && out_first_y == '0 && out_second_x == '0 && out_second_y == '0)
    else $error("coordinates not cleared for a word without points");

  // The count never exceeds two.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_count == cip_pkg::CNT_NONE || out_point_count == cip_pkg::CNT_ONE
                  || out_point_count == cip_pkg::CNT_TWO)
    else $error("point count out of range");

  // Reset empties the output register.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid after reset");

endmodule
`default_nettype wire
